/* src/rom_nibble_sample_player_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ROM nibble sample player
// Concurrent checks are compiled in unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ROM_NIBBLE_SAMPLE_PLAYER_TOP_DEFINES_SVH
`define ROM_NIBBLE_SAMPLE_PLAYER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define RNSP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define RNSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`define RNSP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

`else

`define RNSP_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define RNSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`define RNSP_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* src/rnsp_pkg.sv */
// ----------------------------------------------------------------------------
// ROM nibble sample player package
// Payload types, command and register codes, and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rnsp_pkg;

  localparam int ROM_ADDR_BITS = 16;
  localparam int ROM_DEPTH     = 1 << ROM_ADDR_BITS;

  typedef logic [ROM_ADDR_BITS-1:0] rom_addr_t;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_PLAY = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_ROM_LENGTH = 1'b1;

  localparam int CFG_DATA_BITS = 20;

  localparam logic [19:0] PHASE_STEP_RESET = 20'd5461;
  localparam logic [16:0] ROM_LENGTH_RESET = 17'h10000;

  localparam logic [3:0] NIBBLE_BIAS = 4'h8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  sound_code;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
  } item_t;

  typedef struct packed {
    logic signed [3:0] sample_value;
    logic              playing;
  } result_t;

endpackage

`default_nettype wire

/* src/rom_nibble_sample_player_top.sv */
// A tick result passes the s1, s2 and result registers; result_stall can hold each of them.
// Throughput: ticks and ROM loads are taken one per cycle while not stalled; the
// single ROM read per tick is pipelined. A play command with a nonzero code holds
// item_stall while four index bytes are fetched on the second read port.
// Reset is synchronous; it clears the player state and the registers, not the ROM.
`default_nettype none
`include "rom_nibble_sample_player_top_defines.svh"
// ----------------------------------------------------------------------------
// ROM nibble sample player
// Loads a byte ROM, looks up sample bounds on play and emits 4-bit samples.
// ----------------------------------------------------------------------------
module rom_nibble_sample_player_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire rnsp_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output rnsp_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [rnsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_FETCH = 2'd1;
  localparam logic [1:0] P_CLIP  = 2'd2;
  localparam logic [1:0] P_COUNT = 2'd3;

  logic [19:0] phase_step;
  logic [16:0] rom_length;

  logic [15:0] start_address;
  logic [16:0] end_address;
  logic [17:0] nibble_count;
  logic [17:0] nibble_position;
  logic [15:0] phase_fraction;

  logic [7:0] sample_rom [rnsp_pkg::ROM_DEPTH];
  logic [7:0] rom_a_q;
  logic [7:0] rom_b_q;

  logic [1:0]  play_state;
  logic [2:0]  fetch_step;
  logic [3:0]  play_code;
  logic [7:0]  fetch_byte [4];
  logic [16:0] fetch_end;

  logic        s1_valid;
  logic        s1_active;
  logic [17:0] s1_pos;
  logic [15:0] s1_start;

  logic        s2_valid;
  logic        s2_active;
  logic        s2_odd;
  logic        s2_oob;

  logic c_ready;
  logic s2_ready;
  logic s1_ready;
  logic item_accept;
  logic tick_accept;
  logic play_accept;
  logic rom_we;
  logic rd_a_en;
  logic rd_b_en;

  logic        player_active;
  logic [20:0] tick_sum;
  logic [17:0] tick_pos;
  logic        tick_ended;

  logic [17:0]         b_addr;
  logic                b_oob;
  logic [4:0]          fetch_addr5;
  logic [1:0]          fetch_slot;
  logic [15:0]         fetch_end_raw;
  logic [15:0]         fetch_start;
  logic [16:0]         span;
  logic [7:0]          c_byte;
  logic [3:0]          c_nib;
  rnsp_pkg::result_t   c_result;

  assign cfg_ready = 1'b1;

  assign c_ready  = !result_valid || !result_stall;
  assign s2_ready = !s2_valid || c_ready;
  assign s1_ready = !s1_valid || s2_ready;

  assign item_stall  = (play_state != P_IDLE) || !s1_ready;
  assign item_accept = item_valid && !item_stall;
  assign tick_accept = item_accept && (item.cmd == rnsp_pkg::CMD_TICK);
  assign play_accept = item_accept && (item.cmd == rnsp_pkg::CMD_PLAY) &&
                       (item.sound_code != 4'd0);
  assign rom_we      = item_accept && (item.cmd == rnsp_pkg::CMD_LOAD);
  assign rd_a_en     = s1_valid && s2_ready;
  assign rd_b_en     = (play_state == P_FETCH) && (fetch_step != 3'd4);

  assign player_active = {1'b0, start_address} < end_address;
  assign tick_sum      = {5'd0, phase_fraction} + {1'b0, phase_step};
  assign tick_pos      = nibble_position + {13'd0, tick_sum[20:16]};
  assign tick_ended    = tick_pos > nibble_count;

  assign b_addr = {2'b00, s1_start} + {1'b0, s1_pos[17:1]};
  assign b_oob  = (b_addr >= {1'b0, rom_length}) ||
                  (|b_addr[17:rnsp_pkg::ROM_ADDR_BITS]);

  assign fetch_addr5   = {fetch_step[0], fetch_step[1] ? play_code : play_code - 4'd1};
  assign fetch_slot    = 2'(fetch_step - 3'd1);
  assign fetch_end_raw = {fetch_byte[3], fetch_byte[2]};
  assign fetch_start   = {fetch_byte[1], fetch_byte[0]};
  assign span          = fetch_end - {1'b0, fetch_start};

  assign c_byte = s2_oob ? 8'h00 : rom_a_q;
  assign c_nib  = s2_odd ? c_byte[7:4] : c_byte[3:0];
  assign c_result.sample_value = s2_active ? signed'(c_nib ^ rnsp_pkg::NIBBLE_BIAS) : 4'sd0;
  assign c_result.playing      = s2_active;

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rom_a_q <= sample_rom[b_addr[rnsp_pkg::ROM_ADDR_BITS-1:0]];
    end
    if (rd_b_en) begin
      rom_b_q <= sample_rom[rnsp_pkg::rom_addr_t'(fetch_addr5)];
    end
    if (rom_we) begin
      sample_rom[item.load_address[rnsp_pkg::ROM_ADDR_BITS-1:0]] <= item.load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= rnsp_pkg::PHASE_STEP_RESET;
      rom_length <= rnsp_pkg::ROM_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rnsp_pkg::REG_PHASE_STEP: phase_step <= cfg_data[19:0];
        rnsp_pkg::REG_ROM_LENGTH: rom_length <= cfg_data[16:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_state      <= P_IDLE;
      fetch_step      <= 3'd0;
      start_address   <= 16'd0;
      end_address     <= 17'd0;
      nibble_count    <= 18'd0;
      nibble_position <= 18'd0;
      phase_fraction  <= 16'd0;
    end else begin
      unique case (play_state)
        P_IDLE: begin
          if (play_accept) begin
            play_state <= P_FETCH;
            fetch_step <= 3'd0;
          end
        end
        P_FETCH: begin
          fetch_step <= fetch_step + 3'd1;
          if (fetch_step == 3'd4) begin
            play_state <= P_CLIP;
          end
        end
        P_CLIP: begin
          play_state <= P_COUNT;
        end
        P_COUNT: begin
          play_state      <= P_IDLE;
          start_address   <= fetch_start;
          end_address     <= fetch_end;
          nibble_count    <= (fetch_end > {1'b0, fetch_start}) ? {span, 1'b0} : 18'd0;
          nibble_position <= 18'd0;
          phase_fraction  <= 16'd0;
        end
      endcase
      if (tick_accept && player_active) begin
        if (tick_ended) begin
          start_address   <= 16'd0;
          end_address     <= 17'd0;
          nibble_count    <= 18'd0;
          nibble_position <= 18'd0;
          phase_fraction  <= 16'd0;
        end else begin
          nibble_position <= tick_pos;
          phase_fraction  <= tick_sum[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (play_accept) begin
      play_code <= item.sound_code;
    end
    if (play_state == P_FETCH && fetch_step != 3'd0) begin
      fetch_byte[fetch_slot] <= rom_b_q;
    end
    if (play_state == P_CLIP) begin
      fetch_end <= ({1'b0, fetch_end_raw} >= rom_length) ? rom_length
                                                          : {1'b0, fetch_end_raw};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= tick_accept;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (c_ready) begin
        result_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_active <= player_active && !tick_ended;
      s1_pos    <= tick_pos;
      s1_start  <= start_address;
    end
    if (rd_a_en) begin
      s2_active <= s1_active;
      s2_odd    <= s1_pos[0];
      s2_oob    <= b_oob;
    end
    if (s2_valid && c_ready) begin
      result <= c_result;
    end
  end

  `RNSP_ASSERT_IMPLIES(a_stall_in_play, clk, rst, play_state != P_IDLE, item_stall)
  `RNSP_ASSERT_NEVER(a_no_load_in_play, clk, rst, rom_we && (play_state != P_IDLE))
  `RNSP_ASSERT_IMPLIES(a_idle_cleared, clk, rst, !player_active, (nibble_position == 18'd0) && (phase_fraction == 16'd0))
  `RNSP_ASSERT_IMPLIES(a_silent_when_idle, clk, rst, result_valid && !result.playing, result.sample_value == 4'sd0)

endmodule

`default_nettype wire
